FILE: hdl/frpf_pkg.sv
// Shared types and constants for the rate-paced freshness FIFO.
`default_nettype none

package frpf_pkg;

  // Number of entries in the queue storage.
  localparam int unsigned DEPTH   = 64;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned LIM_W   = (CNT_W > 7) ? CNT_W : 7;

  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned PAYLOAD_W = 32;
  localparam int unsigned ENTRY_W   = STAMP_W + PAYLOAD_W;

  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned QLIM_W   = 7;
  localparam int unsigned CFG_W    = 10;

  // Configuration register indexes.
  localparam logic CFG_TICK_PERIOD = 1'b0;
  localparam logic CFG_QUEUE_LIMIT = 1'b1;

  localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST = PERIOD_W'(100);
  localparam logic [QLIM_W-1:0]   QUEUE_LIMIT_RST = QLIM_W'(4);

  // Command codes.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef enum logic {
    ALU_ADD,
    ALU_CMP
  } alu_op_e;

  typedef struct packed {
    alu_op_e              op;
    logic [STAMP_W-1:0]   a;
    logic [STAMP_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [STAMP_W-1:0] sum;
    logic               ge;
  } alu_rsp_t;

  typedef struct packed {
    logic                        cmd;
    logic [STAMP_W-1:0]          stamp;
    logic signed [PAYLOAD_W-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [STAMP_W-1:0]          out_stamp;
    logic                        out_extrapolated;
    logic signed [PAYLOAD_W-1:0] out_payload;
  } out_item_t;

endpackage

`default_nettype wire

FILE: hdl/frpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module frpf_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/frpf_alu.sv
// Shared 32-bit adder used for stamp compares and marker stamp sums.
`default_nettype none

module frpf_alu
  import frpf_pkg::*;
(
  input  wire alu_req_t req_i,
  output alu_rsp_t      rsp_o
);

  logic [STAMP_W-1:0] b_eff;
  logic               cin;
  logic [STAMP_W:0]   sum;

  always_comb begin
    case (req_i.op)
      ALU_CMP: begin
        b_eff = ~req_i.b;
        cin   = 1'b1;
      end
      default: begin
        b_eff = req_i.b;
        cin   = 1'b0;
      end
    endcase
  end

  assign sum = {1'b0, req_i.a} + {1'b0, b_eff} + {{STAMP_W{1'b0}}, cin};

  // For a subtraction the carry out is set exactly when a >= b, unsigned.
  assign rsp_o.sum = sum[STAMP_W-1:0];
  assign rsp_o.ge  = sum[STAMP_W];

endmodule

`default_nettype wire

FILE: hdl/fresh_item_rate_paced_fifo_top.sv
// Top level of the rate-paced freshness FIFO: sequencer, queue pointers and registers.
`default_nettype none

// An insert beat (cmd = 0) never raises busy: it stores the stamp and payload at
// the tail of the queue, first dropping the oldest entry when the queue already
// holds the effective limit (queue_limit, with 0 read as 1 and values above the
// storage depth read as the depth). A tick beat (cmd = 1) raises busy and walks
// the queue from the head; for each entry examined, S_READ reads it from the
// storage RAM and S_CHECK then compares its stamp against the last sent stamp in
// the shared adder. The first entry whose stamp is not below the last sent stamp
// is emitted; if the queue runs dry first, a marker stamped last sent plus
// tick_period with payload 0 is emitted instead, formed by the adder in S_EXTRAP.
// The result beat appears on result_o for exactly one cycle with result_valid_o
// high, in the same cycle that busy falls; the receiver cannot stall it, so it must
// capture the beat in that cycle. Configuration writes are taken at any edge
// with cfg_we_i high and are meant to happen only while the block is idle.
module fresh_item_rate_paced_fifo_top
  import frpf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire in_item_t   in_item_i,
  output logic            result_valid_o,
  output out_item_t       result_o,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i
);

  // Sequencer state codes.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_READ   = 2'd1;
  localparam logic [1:0] S_CHECK  = 2'd2;
  localparam logic [1:0] S_EXTRAP = 2'd3;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  logic [1:0]          state_q, state_d;
  logic [IDX_W-1:0]    head_q, head_d;
  logic [IDX_W-1:0]    tail_q, tail_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [STAMP_W-1:0]  last_q, last_d;
  logic [PERIOD_W-1:0] tick_period_q;
  logic [QLIM_W-1:0]   queue_limit_q;
  logic                valid_q, valid_d;
  out_item_t           res_q, res_d;

  logic                accept;
  logic                ram_we;
  logic                ram_re;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [LIM_W-1:0]    qlim_ext;
  logic [LIM_W-1:0]    eff_limit;
  logic                drop;
  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_period_q <= TICK_PERIOD_RST;
      queue_limit_q <= QUEUE_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TICK_PERIOD: tick_period_q <= cfg_wdata_i[PERIOD_W-1:0];
        CFG_QUEUE_LIMIT: queue_limit_q <= cfg_wdata_i[QLIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the limit into 1..DEPTH.
  always_comb begin
    qlim_ext = LIM_W'(queue_limit_q);
    if (qlim_ext == '0) begin
      eff_limit = LIM_W'(1);
    end else if (qlim_ext > LIM_W'(DEPTH)) begin
      eff_limit = LIM_W'(DEPTH);
    end else begin
      eff_limit = qlim_ext;
    end
  end

  // A full queue gives up its oldest entry to make room.
  assign drop = (LIM_W'(count_q) >= eff_limit);

  assign ram_we    = accept && (in_item_i.cmd == CMD_INSERT);
  assign ram_wdata = {in_item_i.stamp, in_item_i.payload};
  assign ram_re    = (state_q == S_READ);

  frpf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // The adder compares during the queue walk and forms the marker stamp otherwise.
  always_comb begin
    if (state_q == S_CHECK) begin
      alu_req.op = ALU_CMP;
      alu_req.a  = ram_rdata[ENTRY_W-1:PAYLOAD_W];
      alu_req.b  = last_q;
    end else begin
      alu_req.op = ALU_ADD;
      alu_req.a  = last_q;
      alu_req.b  = STAMP_W'(tick_period_q);
    end
  end

  frpf_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    last_d  = last_q;
    valid_d = 1'b0;
    res_d   = res_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_item_i.cmd == CMD_INSERT) begin
            tail_d = next_slot(tail_q);
            if (drop) begin
              head_d = next_slot(head_q);
            end else begin
              count_d = count_q + 1'b1;
            end
          end else if (count_q == '0) begin
            state_d = S_EXTRAP;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        // The entry just read is popped whatever the compare says.
        head_d  = next_slot(head_q);
        count_d = count_q - 1'b1;
        if (alu_rsp.ge) begin
          state_d                = S_IDLE;
          valid_d                = 1'b1;
          res_d.out_stamp        = ram_rdata[ENTRY_W-1:PAYLOAD_W];
          res_d.out_extrapolated = 1'b0;
          res_d.out_payload      = ram_rdata[PAYLOAD_W-1:0];
          last_d                 = ram_rdata[ENTRY_W-1:PAYLOAD_W];
        end else if (count_q == CNT_W'(1)) begin
          state_d = S_EXTRAP;
        end else begin
          state_d = S_READ;
        end
      end
      S_EXTRAP: begin
        state_d                = S_IDLE;
        valid_d                = 1'b1;
        res_d.out_stamp        = alu_rsp.sum;
        res_d.out_extrapolated = 1'b1;
        res_d.out_payload      = '0;
        last_d                 = alu_rsp.sum;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      last_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      last_q  <= last_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire
